// ===== src/pkcs7_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PKCS#7 pad/unpad stream: shared package
// Widths, register indexes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package pkcs7_pkg;

	localparam int DATA_W            = 8;
	localparam int CNT_W             = 6;
	localparam int CFG_W             = 6;
	localparam int CFG_IDX_W         = 1;
	localparam int MAX_BLOCK_DEFAULT = 32;
	localparam int BS_RESET          = 16;
	localparam int QUEUE_DEPTH       = 4;
	localparam int QUEUE_AW          = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 1'b1;

	// One accepted word, classified by the front end.
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              has_byte;
		logic              eom;
		logic              dir;       // 1: strip padding
		logic              ovf;       // holding buffer full: oldest byte leaves
		logic              ok0;       // length is a nonzero multiple of the block
		logic [CNT_W-1:0]  fill;      // held bytes after this word
		logic [CNT_W-1:0]  bs;        // block size in force
		logic [CNT_W-1:0]  pad_len;   // pad bytes to append at end of message
	} cmd_t;

endpackage

// ===== src/pkcs7_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PKCS#7 pad/unpad stream: channel interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface pkcs7_in_if;
	logic                          valid;
	logic                          ready;
	logic [pkcs7_pkg::DATA_W-1:0]  byte_in;
	logic                          has_byte;
	logic                          end_of_message;

	modport source (output valid, output byte_in, output has_byte, output end_of_message,
		input ready);
	modport sink (input valid, input byte_in, input has_byte, input end_of_message,
		output ready);
endinterface

interface pkcs7_out_if;
	logic                          valid;
	logic                          ready;
	logic [pkcs7_pkg::DATA_W-1:0]  byte_out;
	logic                          byte_valid;
	logic                          last_of_run;
	logic                          status;

	modport source (output valid, output byte_out, output byte_valid, output last_of_run,
		output status, input ready);
	modport sink (input valid, input byte_out, input byte_valid, input last_of_run,
		input status, output ready);
endinterface

// ===== src/pkcs7_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PKCS#7 front end
// Holds the configuration, tracks message position and buffer fill, and
// turns each accepted word into a command for the back end.
// ----------------------------------------------------------------------------
module pkcs7_front #(
	parameter int MAX_BLOCK = pkcs7_pkg::MAX_BLOCK_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	pkcs7_in_if.sink                          in_ch,
	input  logic                              cfg_we,
	input  logic [pkcs7_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pkcs7_pkg::CFG_W-1:0]       cfg_data,
	input  logic                              q_full,
	output logic                              q_push,
	output pkcs7_pkg::cmd_t                   q_cmd
);

	localparam int CW = pkcs7_pkg::CNT_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCK);
	localparam logic [CW-1:0] BS_INIT = (pkcs7_pkg::BS_RESET > MAX_BLOCK) ?
		MAX_CNT : CW'(pkcs7_pkg::BS_RESET);

	logic [CW-1:0] bs_q;
	logic          dir_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] fill_q;

	logic [CW-1:0] pos_inc;
	logic [CW-1:0] pos_nx;
	logic [CW-1:0] fill_nx;
	logic          holds;
	logic          ovf;
	logic [CW-1:0] bs_sat;

	assign in_ch.ready = !q_full;
	assign q_push      = in_ch.valid && !q_full;

	assign pos_inc = pos_q + CW'(1);
	assign pos_nx  = !in_ch.has_byte ? pos_q : ((pos_inc >= bs_q) ? '0 : pos_inc);
	assign holds   = dir_q && in_ch.has_byte;
	assign ovf     = holds && (fill_q >= bs_q);
	assign fill_nx = (holds && !ovf) ? fill_q + CW'(1) : fill_q;

	always_comb begin
		q_cmd.data     = in_ch.byte_in;
		q_cmd.has_byte = in_ch.has_byte;
		q_cmd.eom      = in_ch.end_of_message;
		q_cmd.dir      = dir_q;
		q_cmd.ovf      = ovf;
		q_cmd.ok0      = (pos_nx == '0) && (fill_nx == bs_q);
		q_cmd.fill     = fill_nx;
		q_cmd.bs       = bs_q;
		q_cmd.pad_len  = bs_q - pos_nx;
	end

	// A block size of zero is taken as one; anything above the buffer depth saturates.
	assign bs_sat = (cfg_data == '0) ? CW'(1) : ((cfg_data > MAX_CNT) ? MAX_CNT : cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q   <= BS_INIT;
			dir_q  <= 1'b0;
			pos_q  <= '0;
			fill_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pkcs7_pkg::REG_BLOCK_SIZE: bs_q  <= bs_sat;
				pkcs7_pkg::REG_DIRECTION:  dir_q <= cfg_data[0];
			endcase
			pos_q  <= '0;
			fill_q <= '0;
		end else if (q_push) begin
			pos_q  <= in_ch.end_of_message ? '0 : pos_nx;
			fill_q <= in_ch.end_of_message ? '0 : fill_nx;
		end
	end

`ifndef SYNTHESIS
	a_fill_le_bs: assert property (@(posedge clk) disable iff (!arst_n) fill_q <= bs_q)
		else $error("holding fill exceeds block size");
	a_pos_lt_bs: assert property (@(posedge clk) disable iff (!arst_n) pos_q < bs_q)
		else $error("block position out of range");
`endif

endmodule

// ===== src/pkcs7_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PKCS#7 command queue
// Short FIFO of commands that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module pkcs7_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pkcs7_pkg::cmd_t  wdata,
	output logic             full,
	input  logic             pop,
	output pkcs7_pkg::cmd_t  rdata,
	output logic             empty
);

	localparam int DEPTH = pkcs7_pkg::QUEUE_DEPTH;
	localparam int AW    = pkcs7_pkg::QUEUE_AW;

	pkcs7_pkg::cmd_t slots_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     count_q;

	assign full  = (count_q == (AW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command popped from empty queue");
`endif

endmodule

// ===== src/pkcs7_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PKCS#7 back end
// Sequencer that executes commands: passes bytes, appends pad runs, keeps
// the held block in a ring buffer and checks and releases it at the end.
// ----------------------------------------------------------------------------
module pkcs7_back #(
	parameter int MAX_BLOCK = pkcs7_pkg::MAX_BLOCK_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  pkcs7_pkg::cmd_t  q_cmd,
	output logic             q_pop,
	pkcs7_out_if.source      out_ch
);

	localparam int CW = pkcs7_pkg::CNT_W;
	localparam int DW = pkcs7_pkg::DATA_W;
	localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_PAD      = 4'd1;
	localparam logic [3:0] S_OVF_RD   = 4'd2;
	localparam logic [3:0] S_OVF_EMIT = 4'd3;
	localparam logic [3:0] S_EOM      = 4'd4;
	localparam logic [3:0] S_CHK_RD   = 4'd5;
	localparam logic [3:0] S_CHK_P    = 4'd6;
	localparam logic [3:0] S_SCAN_RD  = 4'd7;
	localparam logic [3:0] S_SCAN_CMP = 4'd8;
	localparam logic [3:0] S_REL_RD   = 4'd9;
	localparam logic [3:0] S_REL_EMIT = 4'd10;
	localparam logic [3:0] S_STATUS   = 4'd11;

	function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [CW:0] sum;
		begin
			sum = (CW+1)'(base) + (CW+1)'(off);
			if (sum >= (CW+1)'(MAX_BLOCK)) begin
				sum = sum - (CW+1)'(MAX_BLOCK);
			end
			return AW'(sum);
		end
	endfunction

	logic [DW-1:0]   mem_q [MAX_BLOCK];
	logic [DW-1:0]   rd_data_q;
	logic [AW-1:0]   rd_addr;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [DW-1:0]   mem_wdata;

	logic [3:0]      state_q, state_d;
	logic [AW-1:0]   head_q, head_d;
	pkcs7_pkg::cmd_t cur_q, cur_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [CW-1:0]   off_q, off_d;
	logic [CW-1:0]   keep_q, keep_d;
	logic [DW-1:0]   p_q, p_d;
	logic            ok_q, ok_d;

	logic            out_valid_q;
	logic [DW-1:0]   out_byte_q;
	logic            out_bv_q;
	logic            out_last_q;
	logic            out_status_q;

	logic            slot_free;
	logic            need_slot;
	logic            emit;
	logic [DW-1:0]   emit_byte;
	logic            emit_bv;
	logic            emit_last;
	logic            emit_status;

	assign slot_free = !out_valid_q || out_ch.ready;
	assign need_slot = !q_cmd.dir && q_cmd.has_byte;
	assign rd_addr   = (state_q == S_OVF_RD || state_q == S_OVF_EMIT) ? head_q :
		ring_addr(head_q, off_q);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		cur_d       = cur_q;
		cnt_d       = cnt_q;
		off_d       = off_q;
		keep_d      = keep_q;
		p_d         = p_q;
		ok_d        = ok_q;
		q_pop       = 1'b0;
		emit        = 1'b0;
		emit_byte   = '0;
		emit_bv     = 1'b0;
		emit_last   = 1'b0;
		emit_status = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = head_q;
		mem_wdata   = cur_q.data;

		unique case (state_q)
			S_IDLE: begin
				if (!q_empty && (!need_slot || slot_free)) begin
					q_pop = 1'b1;
					cur_d = q_cmd;
					if (!q_cmd.dir) begin
						if (q_cmd.has_byte) begin
							emit      = 1'b1;
							emit_byte = q_cmd.data;
							emit_bv   = 1'b1;
						end
						if (q_cmd.eom) begin
							cnt_d   = q_cmd.pad_len;
							state_d = S_PAD;
						end
					end else if (q_cmd.ovf) begin
						state_d = S_OVF_RD;
					end else begin
						if (q_cmd.has_byte) begin
							mem_we    = 1'b1;
							mem_waddr = ring_addr(head_q, q_cmd.fill - CW'(1));
							mem_wdata = q_cmd.data;
						end
						if (q_cmd.eom) begin
							state_d = S_EOM;
						end
					end
				end
			end
			S_PAD: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_byte = DW'(cur_q.pad_len);
					emit_bv   = 1'b1;
					emit_last = (cnt_q == CW'(1));
					cnt_d     = cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			S_OVF_RD: begin
				state_d = S_OVF_EMIT;
			end
			S_OVF_EMIT: begin
				// The oldest byte leaves and the new one goes just past the end of the block.
				if (slot_free) begin
					emit      = 1'b1;
					emit_byte = rd_data_q;
					emit_bv   = 1'b1;
					mem_we    = 1'b1;
					mem_waddr = ring_addr(head_q, cur_q.fill);
					mem_wdata = cur_q.data;
					head_d    = (head_q == AW'(MAX_BLOCK - 1)) ? '0 : head_q + AW'(1);
					state_d   = cur_q.eom ? S_EOM : S_IDLE;
				end
			end
			S_EOM: begin
				ok_d = cur_q.ok0;
				if (cur_q.ok0) begin
					off_d   = cur_q.fill - CW'(1);
					state_d = S_CHK_RD;
				end else begin
					off_d   = '0;
					keep_d  = cur_q.fill;
					state_d = (cur_q.fill == '0) ? S_STATUS : S_REL_RD;
				end
			end
			S_CHK_RD: begin
				state_d = S_CHK_P;
			end
			S_CHK_P: begin
				off_d = '0;
				if (rd_data_q == '0 || rd_data_q > DW'(cur_q.bs)) begin
					ok_d    = 1'b0;
					keep_d  = cur_q.fill;
					state_d = S_REL_RD;
				end else if (rd_data_q == DW'(1)) begin
					keep_d  = cur_q.fill - CW'(1);
					state_d = (cur_q.fill == CW'(1)) ? S_STATUS : S_REL_RD;
				end else begin
					p_d     = rd_data_q;
					off_d   = cur_q.fill - rd_data_q[CW-1:0];
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				// The last byte is the pad length itself; the scan covers the bytes below it.
				if (rd_data_q != p_q) begin
					ok_d    = 1'b0;
					off_d   = '0;
					keep_d  = cur_q.fill;
					state_d = S_REL_RD;
				end else if (off_q + CW'(2) == cur_q.fill) begin
					off_d   = '0;
					keep_d  = cur_q.fill - p_q[CW-1:0];
					state_d = (cur_q.fill == p_q[CW-1:0]) ? S_STATUS : S_REL_RD;
				end else begin
					off_d   = off_q + CW'(1);
					state_d = S_SCAN_RD;
				end
			end
			S_REL_RD: begin
				state_d = S_REL_EMIT;
			end
			S_REL_EMIT: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_byte = rd_data_q;
					emit_bv   = 1'b1;
					off_d     = off_q + CW'(1);
					state_d   = (off_q + CW'(1) == keep_q) ? S_STATUS : S_REL_RD;
				end
			end
			S_STATUS: begin
				if (slot_free) begin
					emit        = 1'b1;
					emit_last   = 1'b1;
					emit_status = !ok_q;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		cnt_q  <= cnt_d;
		off_q  <= off_d;
		keep_q <= keep_d;
		p_q    <= p_d;
		ok_q   <= ok_d;
		if (emit) begin
			out_byte_q   <= emit_byte;
			out_bv_q     <= emit_bv;
			out_last_q   <= emit_last;
			out_status_q <= emit_status;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.byte_out    = out_byte_q;
	assign out_ch.byte_valid  = out_bv_q;
	assign out_ch.last_of_run = out_last_q;
	assign out_ch.status      = out_status_q;

`ifndef SYNTHESIS
	a_pad_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PAD) |-> (cnt_q != '0))
		else $error("pad run entered with zero count");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_bv_q) |-> out_last_q)
		else $error("status word not marked last");
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> slot_free)
		else $error("result word overwrote a pending word");
`endif

endmodule

// ===== src/pkcs7_pad_unpad_stream_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PKCS#7 pad/unpad stream: top level
// Byte-stream padder and unpadder with configurable block size and direction.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one word per handshake: an optional message byte and an
//   end-of-message flag. out_ch carries result words: a byte, or a final
//   status word when stripping padding. cfg_we/cfg_index/cfg_data write the
//   block size (index 0) or the direction (index 1); a write drops any
//   message in progress and must only happen while the block is idle.
//   A front end classifies words into a four-entry command queue; a back-end
//   sequencer executes them and takes a new command only while idle. An
//   accepted word passes through the command queue and the output register
//   before its first result. In pad direction the end of message starts the
//   pad run, one pad byte per result word. In strip direction a byte that
//   pushes out the oldest held byte first reads the ring buffer, and at the
//   end of message each check and release step reads the single ring buffer
//   port; a failed pad scan is followed by the release of the whole block.
//   Reset empties the queue and output register and sets block size 16 and
//   pad direction. When out_ch stalls, the output register holds its word,
//   the sequencer waits, and in_ch stays ready until the queue fills.
// ----------------------------------------------------------------------------
module pkcs7_pad_unpad_stream_top #(
	parameter int MAX_BLOCK = pkcs7_pkg::MAX_BLOCK_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	pkcs7_in_if.sink                          in_ch,
	pkcs7_out_if.source                       out_ch,
	input  logic                              cfg_we,
	input  logic [pkcs7_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pkcs7_pkg::CFG_W-1:0]       cfg_data
);

	pkcs7_pkg::cmd_t push_cmd;
	pkcs7_pkg::cmd_t pop_cmd;
	logic            q_push;
	logic            q_pop;
	logic            q_full;
	logic            q_empty;

	pkcs7_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	pkcs7_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (pop_cmd),
		.empty  (q_empty)
	);

	pkcs7_back #(.MAX_BLOCK(MAX_BLOCK)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_cmd   (pop_cmd),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

// ===== tb/pkcs7_pad_unpad_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PKCS#7 pad/unpad stream: result checker
// Watches the input, result and register ports, works out the result words
// each accepted input word should cause, and compares them in order.
// ----------------------------------------------------------------------------
module pkcs7_pad_unpad_stream_checker #(
	parameter int MAX_BLOCK = pkcs7_pkg::MAX_BLOCK_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	pkcs7_in_if                             in_ch,
	pkcs7_out_if                            out_ch,
	input  logic                            cfg_we,
	input  logic [pkcs7_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pkcs7_pkg::CFG_W-1:0]     cfg_data,
	output int                              errors,
	output int                              pending,
	output int                              results_seen,
	output int                              error_status_seen
);
	import pkcs7_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              byte_valid;
		logic              last;
		logic              status;
	} result_word_t;

	result_word_t      owed_words[$];
	logic [DATA_W-1:0] held_bytes[$];
	logic [CNT_W-1:0]  blk_size;
	logic [CNT_W-2:0]  blk_pos;
	logic              strip_mode;
	result_word_t      want;

	task automatic report(input string what, input int want_val, input int got_val);
		errors++;
		if (errors <= 40)
			$display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what,
				want_val, got_val);
	endtask

	function automatic void owe(input logic [DATA_W-1:0] d, input logic v, input logic l,
		input logic s);
		result_word_t w;
		w.data       = d;
		w.byte_valid = v;
		w.last       = l;
		w.status     = s;
		owed_words.push_back(w);
	endfunction

	// Works out the result words caused by one accepted input word.
	function automatic void pad_or_strip(input logic [DATA_W-1:0] b, input logic hb,
		input logic eom);
		int unsigned bs;
		int unsigned p;
		int unsigned keep;
		int unsigned i;
		logic        ok;
		bs = blk_size;
		if (hb) begin
			if (strip_mode) begin
				// A full holding buffer pushes its oldest byte out.
				if (held_bytes.size() >= bs)
					owe(held_bytes.pop_front(), 1'b1, 1'b0, 1'b0);
				held_bytes.push_back(b);
			end else begin
				owe(b, 1'b1, 1'b0, 1'b0);
			end
			blk_pos = (blk_pos + 1 >= bs) ? '0 : blk_pos + 1'b1;
		end
		if (eom) begin
			if (!strip_mode) begin
				p = bs - blk_pos;
				for (i = 0; i < p; i++)
					owe(p[DATA_W-1:0], 1'b1, i == p - 1, 1'b0);
			end else begin
				keep = held_bytes.size();
				ok = (blk_pos == 0) && (keep == bs) && (keep > 0);
				p = 0;
				if (ok) begin
					p = held_bytes[keep-1];
					if (p == 0 || p > bs)
						ok = 1'b0;
				end
				if (ok)
					for (i = keep - p; i < keep; i++)
						if (held_bytes[i] != p)
							ok = 1'b0;
				if (ok)
					keep = keep - p;
				for (i = 0; i < keep; i++)
					owe(held_bytes[i], 1'b1, 1'b0, 1'b0);
				owe('0, 1'b0, 1'b1, !ok);
			end
			held_bytes.delete();
			blk_pos = '0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_words.delete();
			held_bytes.delete();
			blk_size          = (BS_RESET > MAX_BLOCK) ? CNT_W'(MAX_BLOCK) : CNT_W'(BS_RESET);
			blk_pos           = '0;
			strip_mode        = 1'b0;
			errors            = 0;
			pending           = 0;
			results_seen      = 0;
			error_status_seen = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (out_ch.status === 1'b1)
					error_status_seen++;
				if (owed_words.size() == 0) begin
					report("unexpected result word", 0, out_ch.byte_out);
				end else begin
					want = owed_words.pop_front();
					if (out_ch.byte_out !== want.data)
						report("byte_out", want.data, out_ch.byte_out);
					if (out_ch.byte_valid !== want.byte_valid)
						report("byte_valid", want.byte_valid, out_ch.byte_valid);
					if (out_ch.last_of_run !== want.last)
						report("last_of_run", want.last, out_ch.last_of_run);
					if (out_ch.status !== want.status)
						report("status", want.status, out_ch.status);
				end
			end
			if (cfg_we) begin
				// Any register write drops the message in progress.
				if (cfg_index == REG_BLOCK_SIZE) begin
					if (cfg_data == 0)
						blk_size = CNT_W'(1);
					else if (cfg_data > MAX_BLOCK)
						blk_size = CNT_W'(MAX_BLOCK);
					else
						blk_size = cfg_data;
				end else begin
					strip_mode = cfg_data[0];
				end
				held_bytes.delete();
				blk_pos = '0;
			end
			if (in_ch.valid && in_ch.ready)
				pad_or_strip(in_ch.byte_in, in_ch.has_byte, in_ch.end_of_message);
			pending = owed_words.size();
		end
	end

endmodule

// ===== tb/tb_pkcs7_pad_unpad_stream_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PKCS#7 pad/unpad stream: testbench top
// Drives directed and random messages in both directions over many block
// sizes, with random gaps on both channels; the checker compares results.
// ----------------------------------------------------------------------------
module tb_pkcs7_pad_unpad_stream_top;
	import pkcs7_pkg::*;

	localparam int MAX_BLK       = MAX_BLOCK_DEFAULT;
	localparam int SETTLE_CYCLES = 80;
	localparam int STALL_LIMIT   = 1000;
	localparam int RANDOM_WORDS  = 250;

	typedef enum {CLEAN, BAD_LENGTH, BAD_COUNT, BAD_FILL, RAW} msg_shape_t;
	typedef logic [DATA_W-1:0] msg_bytes_t[$];

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int errors, pending, results_seen, error_status_seen;
	int item_words, messages_sent, reg_writes, stall_cycles;
	int cur_bs;
	bit cur_strip;
	bit no_idle;

	pkcs7_in_if  in_ch ();
	pkcs7_out_if out_ch ();

	pkcs7_pad_unpad_stream_top #(.MAX_BLOCK(MAX_BLK)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pkcs7_pad_unpad_stream_checker #(.MAX_BLOCK(MAX_BLK)) u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_ch             (in_ch),
		.out_ch            (out_ch),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.errors            (errors),
		.pending           (pending),
		.results_seen      (results_seen),
		.error_status_seen (error_status_seen)
	);

	always #5 clk = ~clk;

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 7);
	endfunction

	// Result side: random stalls before each word.
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap();
			@(negedge clk);
			if (gap > 0) begin
				out_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// Ends the run when neither channel moves for too long.
	initial begin
		stall_cycles = 0;
		wait (arst_n === 1'b1);
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
		$display("tb_pkcs7_pad_unpad_stream_top: errors");
		$finish;
	end

	task automatic put_word(input logic [DATA_W-1:0] b, input logic hb, input logic eom);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid          = 1'b1;
		in_ch.byte_in        = b;
		in_ch.has_byte       = hb;
		in_ch.end_of_message = eom;
		do @(posedge clk); while (!in_ch.ready);
		if (hb || eom)
			item_words++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid = 1'b0;
		wait (pending == 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		drain();
		// Held bytes cause no result, so give the block time to finish them.
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		reg_writes++;
		if (idx == REG_BLOCK_SIZE)
			cur_bs = (val == 0) ? 1 : ((val > MAX_BLK) ? MAX_BLK : val);
		else
			cur_strip = val[0];
	endtask

	task automatic send_bytes(input msg_bytes_t msg, input bit glue, input int pause_at);
		int k;
		for (k = 0; k < msg.size(); k++) begin
			if (k == pause_at)
				drain();
			if ($urandom_range(0, 7) == 0)
				put_word(DATA_W'($urandom_range(0, 255)), 1'b0, 1'b0);
			put_word(msg[k], 1'b1, glue && (k == msg.size() - 1));
		end
		if (!glue || msg.size() == 0)
			put_word(DATA_W'($urandom_range(0, 255)), 1'b0, 1'b1);
		messages_sent++;
	endtask

	function automatic msg_bytes_t build_message(input int data_len, input msg_shape_t shape);
		msg_bytes_t m;
		int         p;
		int         k;
		for (k = 0; k < data_len; k++)
			m.push_back(DATA_W'($urandom_range(0, 255)));
		if (!cur_strip || shape == RAW)
			return m;
		p = cur_bs - data_len % cur_bs;
		repeat (p) m.push_back(p[DATA_W-1:0]);
		case (shape)
			BAD_LENGTH: begin
				if ($urandom_range(0, 1))
					void'(m.pop_back());
				else
					m.push_back(DATA_W'($urandom_range(0, 255)));
			end
			BAD_COUNT: begin
				if ($urandom_range(0, 1))
					m[m.size()-1] = '0;
				else
					m[m.size()-1] = DATA_W'($urandom_range(cur_bs + 1, 255));
			end
			BAD_FILL: begin
				if (p >= 2) begin
					k = m.size() - 1 - $urandom_range(1, p - 1);
					m[k] = m[k] ^ (8'h01 << $urandom_range(0, 7));
				end
			end
			default: ;
		endcase
		return m;
	endfunction

	initial begin
		msg_bytes_t msg;
		msg_shape_t shape;
		int         n_msgs;
		int         len;
		int         pause_at;
		int         k;
		bit         paused_once;

		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		in_ch.valid          = 1'b0;
		in_ch.byte_in        = '0;
		in_ch.has_byte       = 1'b0;
		in_ch.end_of_message = 1'b0;
		item_words           = 0;
		messages_sent        = 0;
		reg_writes           = 0;
		cur_bs               = BS_RESET;
		cur_strip            = 1'b0;
		no_idle              = 1'b0;
		paused_once          = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Out of reset: pad direction, block size 16. An empty message is one pad block.
		msg.delete();
		send_bytes(msg, 1'b0, -1);
		msg = {8'h00, 8'hFF};
		send_bytes(msg, 1'b1, -1);
		write_reg(REG_BLOCK_SIZE, 6'd0);
		msg = {8'hA5};
		send_bytes(msg, 1'b1, -1);
		write_reg(REG_BLOCK_SIZE, 6'd63);
		msg.delete();
		send_bytes(msg, 1'b0, -1);

		// Strip direction with one-byte blocks: pad value zero and too large both fail.
		write_reg(REG_DIRECTION, 6'd1);
		write_reg(REG_BLOCK_SIZE, 6'd1);
		msg = {8'h01};
		send_bytes(msg, 1'b1, -1);
		msg = {8'h00};
		send_bytes(msg, 1'b1, -1);
		msg = {8'h02};
		send_bytes(msg, 1'b1, -1);
		msg.delete();
		send_bytes(msg, 1'b0, -1);

		write_reg(REG_BLOCK_SIZE, 6'd4);
		msg = {8'h11, 8'h22, 8'h02, 8'h02};
		send_bytes(msg, 1'b1, -1);
		msg = {8'h11, 8'h22, 8'h01, 8'h02};
		send_bytes(msg, 1'b1, -1);
		msg = {8'h11, 8'h22, 8'h02};
		send_bytes(msg, 1'b1, -1);
		// Two blocks: the first one is pushed out of the holding buffer.
		msg = {8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h04, 8'h04, 8'h04, 8'h04};
		send_bytes(msg, 1'b1, -1);
		// Left unfinished; the next register write drops these bytes.
		put_word(8'h5A, 1'b1, 1'b0);
		put_word(8'h01, 1'b1, 1'b0);

		while (item_words < RANDOM_WORDS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1))
				write_reg(REG_DIRECTION, CFG_W'($urandom_range(0, 63)));
			case ($urandom_range(0, 9))
				7:       write_reg(REG_BLOCK_SIZE, CFG_W'($urandom_range(9, 32)));
				8:       write_reg(REG_BLOCK_SIZE, 6'd0);
				9:       write_reg(REG_BLOCK_SIZE, CFG_W'($urandom_range(33, 63)));
				default: write_reg(REG_BLOCK_SIZE, CFG_W'($urandom_range(1, 8)));
			endcase
			if ($urandom_range(0, 1))
				write_reg(REG_DIRECTION, CFG_W'($urandom_range(0, 63)));
			n_msgs = (cur_bs > 8) ? $urandom_range(1, 2) : $urandom_range(2, 5);
			repeat (n_msgs) begin
				len = (cur_bs > 8) ? $urandom_range(0, cur_bs + 3)
					: $urandom_range(0, 2 * cur_bs + 2);
				case ($urandom_range(0, 7))
					5:       shape = BAD_LENGTH;
					6:       shape = $urandom_range(0, 1) ? BAD_COUNT : BAD_FILL;
					7:       shape = RAW;
					default: shape = CLEAN;
				endcase
				msg = build_message(len, shape);
				pause_at = -1;
				if (msg.size() > 0 && (!paused_once || $urandom_range(0, 9) == 0)) begin
					pause_at    = msg.size() / 2;
					paused_once = 1'b1;
				end
				send_bytes(msg, 1'($urandom_range(0, 1)), pause_at);
			end
			if ($urandom_range(0, 2) == 0)
				for (k = $urandom_range(1, 3); k > 0; k--)
					put_word(DATA_W'($urandom_range(0, 255)), 1'b1, 1'b0);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("sent %0d input words in %0d messages, with %0d register writes",
			item_words, messages_sent, reg_writes);
		$display("checked %0d result words, %0d of them with padding-error status",
			results_seen, error_status_seen);
		if (errors == 0 && pending == 0)
			$display("tb_pkcs7_pad_unpad_stream_top: clean");
		else
			$display("tb_pkcs7_pad_unpad_stream_top: errors");
		$finish;
	end

endmodule
